>>> rtl/adeos_pkg.sv
`timescale 1ns / 1ps
// Shared widths, constants and mode codes for the audio DAC effect output stage.
// No dependencies; every other file in rtl/ imports this package.
package adeos_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int KNOB_W     = 7;
  localparam int GAIN_W     = 12;
  localparam int LEVEL_W    = 12;
  localparam int DAC_W      = 14;
  localparam int MODE_W     = 2;
  localparam int PROD_W     = SAMPLE_W + 1 + GAIN_W;
  localparam int MASK_NUM_W = 13;

  localparam logic [MODE_W-1:0] MODE_PLAIN = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DECIM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CRUSH = 2'd2;

  localparam logic [GAIN_W-1:0]         FULL_GAIN = 12'd4095;
  localparam logic signed [13:0]        MID_LEVEL = 14'sd2047;
  localparam logic [DAC_W-1:0]          DAC_TAG   = 14'h3000;
  localparam logic [MASK_NUM_W-1:0]     MASK_NUM  = 13'd4096;
  localparam logic [KNOB_W-1:0]         DECIM_MIN = 7'd10;
  localparam logic [KNOB_W-1:0]         KNOB_ONE  = 7'd1;

endpackage

>>> rtl/adeos_smul.sv
`timescale 1ns / 1ps
// Serial signed-by-unsigned multiplier: one multiplier bit per cycle, shift-add.
// Depends on adeos_pkg for the operand and product widths.
module adeos_smul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [adeos_pkg::SAMPLE_W-1:0] multiplicand,
  input  logic [adeos_pkg::GAIN_W-1:0]        multiplier,
  output logic                                busy,
  output logic signed [adeos_pkg::PROD_W-1:0] product
);
  import adeos_pkg::*;

  localparam int CNT_W = $clog2(GAIN_W + 1);
  localparam int HI_W  = SAMPLE_W + 1;

  logic signed [SAMPLE_W-1:0] mcand;
  logic signed [HI_W-1:0]     hi;
  logic [GAIN_W-1:0]          lo;
  logic [CNT_W-1:0]           cnt;
  logic signed [HI_W-1:0]     sum;

  // The low half starts as the multiplier and fills with product bits.
  assign sum = hi + (lo[0] ? HI_W'(mcand) : HI_W'(0));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(GAIN_W);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= multiplicand;
      hi    <= '0;
      lo    <= multiplier;
    end else if (cnt != '0) begin
      hi <= sum >>> 1;
      lo <= {sum[0], lo[GAIN_W-1:1]};
    end
  end

  assign busy    = (cnt != '0);
  assign product = {hi, lo};

endmodule

>>> rtl/adeos_sdiv.sv
`timescale 1ns / 1ps
// Serial restoring divider: one quotient bit per cycle, 7-bit divisor.
// Depends on adeos_pkg for the divisor width.
module adeos_sdiv #(
  parameter int NUM_W = 13
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [NUM_W-1:0]                 num,
  input  logic [adeos_pkg::KNOB_W-1:0]     den,
  output logic                             busy,
  output logic [NUM_W-1:0]                 quot,
  output logic [adeos_pkg::KNOB_W-1:0]     rem
);
  import adeos_pkg::*;

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0]  nq;
  logic [KNOB_W-1:0] r;
  logic [KNOB_W-1:0] d;
  logic [CNT_W-1:0]  cnt;
  logic [KNOB_W:0]   trial;
  logic              qbit;
  logic [KNOB_W:0]   diff;
  logic [NUM_W:0]    nq_shift;

  always_comb begin
    trial    = {r, nq[NUM_W-1]};
    qbit     = (trial >= {1'b0, d});
    diff     = trial - {1'b0, d};
    nq_shift = {nq, qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(NUM_W);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Numerator bits shift out the top while quotient bits enter the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      nq <= num;
      r  <= '0;
      d  <= den;
    end else if (cnt != '0) begin
      nq <= nq_shift[NUM_W-1:0];
      r  <= qbit ? diff[KNOB_W-1:0] : trial[KNOB_W-1:0];
    end
  end

  assign busy = (cnt != '0);
  assign quot = nq;
  assign rem  = r;

endmodule

>>> rtl/audio_dac_effect_output_stage.sv
`timescale 1ns / 1ps
// Top level of the audio DAC effect output stage: control, block position, result register.
// Depends on adeos_pkg, adeos_smul and adeos_sdiv.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one audio tick: sample, track_active,
//   knob_a, knob_b. A tick with track_active low is taken and dropped with no result
//   and no change of position. An active tick advances the block position and gives
//   one result item on the output channel (out_valid/out_ready): dac_word, send,
//   block_done, playing_half.
//   The configuration channel (cfg_valid/cfg_ready, data effect_mode) is always ready;
//   write it only while no item is in flight.
//   The serial units (the 13-step dividers that form 4096/knob, the gain multiplier
//   and the position modulo) start together on an active tick; the result register
//   loads once all of them are idle and the output register is free.
//   in_ready is high whenever control is idle, even while a result still
//   waits in the output register; if the receiver stalls, the next result is held in
//   the units until the output register frees up.
//   Reset (synchronous, rst high) clears mode to plain, position to 0, the playing
//   half to 0 and drops any pending result.
module audio_dac_effect_output_stage #(
  parameter int BLOCK_LEN = 128
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [adeos_pkg::MODE_W-1:0]         effect_mode,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [adeos_pkg::SAMPLE_W-1:0] sample,
  input  logic                                 track_active,
  input  logic [adeos_pkg::KNOB_W-1:0]         knob_a,
  input  logic [adeos_pkg::KNOB_W-1:0]         knob_b,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [adeos_pkg::DAC_W-1:0]          dac_word,
  output logic                                 send,
  output logic                                 block_done,
  output logic                                 playing_half
);
  import adeos_pkg::*;

  localparam int POS_W = $clog2(BLOCK_LEN);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_CALC = 2'b10
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [MODE_W-1:0]   mode;
  logic [POS_W-1:0]    pos;
  logic                playing_select;
  logic [KNOB_W-1:0]   ka;
  logic [KNOB_W-1:0]   kb;
  logic                done;

  logic                in_fire;
  logic                start;
  logic                load_out;
  logic [POS_W:0]      pos_inc;
  logic                wrap;
  logic [POS_W-1:0]    pos_next;
  logic [GAIN_W-1:0]   gain;

  logic                mul_busy;
  logic                diva_busy;
  logic                divb_busy;
  logic                mod_busy;
  logic                any_busy;
  logic signed [PROD_W-1:0]   prod;
  logic [MASK_NUM_W-1:0]      qa;
  logic [MASK_NUM_W-1:0]      qb;
  logic [KNOB_W-1:0]          rem_a;
  logic [KNOB_W-1:0]          rem_b;
  logic [POS_W-1:0]           pos_quot;
  logic [KNOB_W-1:0]          pos_rem;

  logic signed [12:0]  prod_hi;
  logic signed [13:0]  lvl_s;
  logic [LEVEL_W-1:0]  level;
  logic                send_calc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign start     = in_fire && track_active;
  assign any_busy  = mul_busy || diva_busy || divb_busy || mod_busy;
  assign load_out  = (state == S_CALC) && !any_busy && (!out_valid || out_ready);

  always_comb begin
    pos_inc  = {1'b0, pos} + (POS_W + 1)'(1);
    wrap     = (pos_inc >= (POS_W + 1)'(BLOCK_LEN));
    pos_next = wrap ? '0 : pos_inc[POS_W-1:0];
    gain     = (mode == MODE_DECIM) ? (FULL_GAIN - GAIN_W'(knob_b)) : FULL_GAIN;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      mode           <= MODE_PLAIN;
      pos            <= '0;
      playing_select <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        mode <= effect_mode;
      end
      if (start) begin
        pos <= pos_next;
        if (wrap) begin
          playing_select <= ~playing_select;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ka   <= knob_a;
      kb   <= knob_b;
      done <= wrap;
    end
    if (load_out) begin
      dac_word     <= DAC_TAG | DAC_W'(level);
      send         <= send_calc;
      block_done   <= done;
      playing_half <= playing_select;
    end
  end

  adeos_smul u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .multiplicand (sample),
    .multiplier   (gain),
    .busy         (mul_busy),
    .product      (prod)
  );

  adeos_sdiv #(.NUM_W(MASK_NUM_W)) u_div_a (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .num   (MASK_NUM),
    .den   (knob_a),
    .busy  (diva_busy),
    .quot  (qa),
    .rem   (rem_a)
  );

  adeos_sdiv #(.NUM_W(MASK_NUM_W)) u_div_b (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .num   (MASK_NUM),
    .den   (knob_b),
    .busy  (divb_busy),
    .quot  (qb),
    .rem   (rem_b)
  );

  adeos_sdiv #(.NUM_W(POS_W)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .num   (pos_next),
    .den   (knob_a),
    .busy  (mod_busy),
    .quot  (pos_quot),
    .rem   (pos_rem)
  );

  // Level is floor(product / 65536) + 2047, clamped at zero; before the crush masks it never exceeds 4094.
  always_comb begin
    prod_hi = prod[PROD_W-1 -: 13];
    lvl_s   = {prod_hi[12], prod_hi} + MID_LEVEL;
    level   = lvl_s[13] ? '0 : lvl_s[LEVEL_W-1:0];
    if (mode == MODE_CRUSH) begin
      if (ka > KNOB_ONE) begin
        level = level & qa[LEVEL_W-1:0];
      end
      if (kb > KNOB_ONE) begin
        level = level ^ qb[LEVEL_W-1:0];
      end
    end
    send_calc = 1'b1;
    if (mode == MODE_DECIM && ka > DECIM_MIN) begin
      send_calc = (pos_rem == '0);
    end
  end

`ifndef SYNTH
  a_idle_units_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !any_busy)
    else $error("serial unit busy while control is idle");

  a_pos_in_block: assert property (@(posedge clk) disable iff (rst)
    {1'b0, pos} < (POS_W + 1)'(BLOCK_LEN))
    else $error("block position out of range");

  a_wrap_flips_half: assert property (@(posedge clk) disable iff (rst)
    (start && wrap) |=> (pos == '0) && (playing_select != $past(playing_select)))
    else $error("block end did not reset position and flip half");

  a_dac_tag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (dac_word[DAC_W-1 -: 2] == 2'b11))
    else $error("dac word lost its command tag");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for audio_dac_effect_output_stage: random and directed ticks
// through valid/ready, each result checked against an in-bench level and position model.
// Depends on adeos_pkg and the RTL of the block.
module testbench;
  import adeos_pkg::*;

  localparam int BLOCK_LEN      = 128;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int GAIN_TOP       = 4095;
  localparam int LEVEL_BIAS     = 2047 * 65536;
  localparam int CRUSH_DIVIDEND = 4096;
  localparam int DECIM_FLOOR    = 10;
  localparam logic [DAC_W-1:0]  WORD_PREFIX = 14'h3000;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  typedef struct {
    logic signed [SAMPLE_W-1:0] smp;
    logic                       active;
    logic [KNOB_W-1:0]          ka;
    logic [KNOB_W-1:0]          kb;
    bit                         hold_for_drain;
  } tick_t;

  typedef struct {
    logic [DAC_W-1:0] word;
    logic             send;
    logic             done;
    logic             half;
  } dac_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [MODE_W-1:0]          effect_mode = MODE_PLAIN;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       track_active = 1'b0;
  logic [KNOB_W-1:0]          knob_a = '0;
  logic [KNOB_W-1:0]          knob_b = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [DAC_W-1:0]           dac_word;
  logic                       send;
  logic                       block_done;
  logic                       playing_half;

  tick_t       tick_queue[$];
  dac_result_t dac_expect[$];
  tick_t       cur_tick;

  // model state
  logic [MODE_W-1:0] mode_q = MODE_PLAIN;
  int                blk_pos = 0;
  logic              half_sel = 1'b0;

  int  n_errors = 0;
  int  cycle_cnt = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  send_calm = 1'b0;
  bit  recv_calm = 1'b0;

  audio_dac_effect_output_stage #(
    .BLOCK_LEN(BLOCK_LEN)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .effect_mode  (effect_mode),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .track_active (track_active),
    .knob_a       (knob_a),
    .knob_b       (knob_b),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dac_word     (dac_word),
    .send         (send),
    .block_done   (block_done),
    .playing_half (playing_half)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    n_errors++;
  endtask

  // Advance position and half, then form the DAC word for one active tick.
  function automatic void predict_dac(input tick_t t);
    dac_result_t       r;
    int                gain;
    longint            acc;
    logic [LEVEL_W-1:0] lvl;
    if (!t.active) return;
    r.done = 1'b0;
    if (blk_pos == BLOCK_LEN - 1) begin
      blk_pos = 0;
      half_sel = ~half_sel;
      r.done = 1'b1;
    end else begin
      blk_pos++;
    end
    gain = (mode_q == MODE_DECIM) ? GAIN_TOP - int'(t.kb) : GAIN_TOP;
    acc = longint'(t.smp) * gain + LEVEL_BIAS;
    lvl = (acc < 0) ? '0 : acc[LEVEL_W+15:16];
    if (mode_q == MODE_CRUSH) begin
      if (t.ka > 1) lvl = lvl & LEVEL_W'(CRUSH_DIVIDEND / int'(t.ka));
      if (t.kb > 1) lvl = lvl ^ LEVEL_W'(CRUSH_DIVIDEND / int'(t.kb));
    end
    r.send = 1'b1;
    if (mode_q == MODE_DECIM && t.ka > DECIM_FLOOR) r.send = (blk_pos % int'(t.ka) == 0);
    r.word = WORD_PREFIX | DAC_W'(lvl);
    r.half = half_sel;
    dac_expect.push_back(r);
  endfunction

  // Input side: present queued ticks, idle a drawn number of cycles after each.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_dac(cur_tick);
        gap_left = send_calm ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 29) == 0) send_calm = !send_calm;
      end
      if (in_valid && !in_ready) begin
        // hold the item until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (tick_queue.size() != 0 &&
                   !(tick_queue[0].hold_for_drain && dac_expect.size() != 0)) begin
        cur_tick = tick_queue.pop_front();
        in_valid     <= 1'b1;
        sample       <= cur_tick.smp;
        track_active <= cur_tick.active;
        knob_a       <= cur_tick.ka;
        knob_b       <= cur_tick.kb;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output side: check each taken result, then stall a drawn number of cycles.
  always @(posedge clk) begin
    dac_result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (dac_expect.size() == 0) begin
          report_mismatch("result with nothing pending", dac_word, 0);
        end else begin
          want = dac_expect.pop_front();
          if (dac_word !== want.word)
            report_mismatch("dac_word", dac_word, want.word);
          if (send !== want.send) report_mismatch("send", send, want.send);
          if (block_done !== want.done) report_mismatch("block_done", block_done, want.done);
          if (playing_half !== want.half)
            report_mismatch("playing_half", playing_half, want.half);
        end
        stall_left = recv_calm ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 29) == 0) recv_calm = !recv_calm;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_mode(input logic [MODE_W-1:0] m);
    @(posedge clk);
    cfg_valid   <= 1'b1;
    effect_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mode_q = m;
  endtask

  task automatic push_tick(input int smp, input bit active, input int ka, input int kb);
    tick_t t;
    t.smp = SAMPLE_W'(smp);
    t.active = active;
    t.ka = KNOB_W'(ka);
    t.kb = KNOB_W'(kb);
    t.hold_for_drain = 1'b0;
    tick_queue.push_back(t);
  endtask

  task automatic push_random(input int n);
    tick_t t;
    for (int k = 0; k < n; k++) begin
      t.active = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 7))
        0:       t.smp = 16'sh7FFF;
        1:       t.smp = 16'sh8000;
        2:       t.smp = SAMPLE_W'($urandom_range(0, 16) - 8);
        default: t.smp = SAMPLE_W'($urandom());
      endcase
      t.ka = ($urandom_range(0, 3) == 0) ? KNOB_W'($urandom_range(0, 12))
                                         : KNOB_W'($urandom_range(0, 127));
      t.kb = ($urandom_range(0, 3) == 0) ? KNOB_W'($urandom_range(0, 12))
                                         : KNOB_W'($urandom_range(0, 127));
      t.hold_for_drain = ($urandom_range(0, 49) == 0) || (k == n / 2);
      tick_queue.push_back(t);
    end
  endtask

  // Wait until every tick is taken and every result is in, then let idle ticks finish.
  task automatic settle();
    do @(negedge clk);
    while (tick_queue.size() != 0 || in_valid || dac_expect.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_mode(MODE_PLAIN);
    push_tick(32767, 1, 0, 0);
    push_tick(-32768, 1, 0, 0);
    push_tick(0, 1, 0, 0);
    push_tick(-1, 1, 0, 0);
    push_tick(1, 1, 127, 127);
    push_tick(1234, 0, 5, 5);
    push_tick(-16, 1, 64, 3);
    settle();

    write_mode(MODE_DECIM);
    push_tick(32767, 1, 0, 127);
    push_tick(-32768, 1, 10, 0);
    push_tick(12345, 1, 11, 5);
    push_tick(100, 1, 127, 127);
    push_tick(-5000, 1, 1, 64);
    push_random(130);
    settle();

    write_mode(MODE_CRUSH);
    push_tick(32767, 1, 0, 0);
    push_tick(32767, 1, 1, 1);
    push_tick(32767, 1, 2, 2);
    push_tick(0, 1, 127, 127);
    push_tick(-32768, 1, 3, 127);
    push_tick(16'h5555, 1, 64, 0);
    push_random(130);
    settle();

    write_mode(MODE_UNUSED);
    push_tick(32767, 1, 20, 100);
    push_tick(-20000, 1, 2, 2);
    push_random(70);
    settle();

    write_mode(MODE_PLAIN);
    push_random(110);
    settle();

    write_mode(MODE_DECIM);
    push_random(110);
    settle();

    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/adeos_pkg.sv
rtl/adeos_smul.sv
rtl/adeos_sdiv.sv
rtl/audio_dac_effect_output_stage.sv
tb/testbench.sv
